### rtl/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types, codes and helpers of the DDA line rasteriser.
// ----------------------------------------------------------------------------
package dda_pkg;

    // item codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_DATA_W-1:0] IMG_SIZE_RESET = 13'd400;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic              op;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } t_dda_in;

    typedef struct packed {
        logic signed [11:0] pixel_x;
        logic signed [11:0] pixel_y;
        logic               inside_res;
        logic               last;
    } t_dda_out;

    // classified item as held in the queue
    typedef struct packed {
        logic               op;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [15:0]        mag_x;
        logic [15:0]        mag_y;
        logic               neg_x;
        logic               neg_y;
        logic               up_x;
        logic               up_y;
        logic [15:0]        len;
    } t_dda_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_dda_q_status;

    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } t_back_state;

    // clamp a 14-bit pixel index to the 12-bit output range
    function automatic logic [11:0] sat12(input logic [13:0] v);
        logic [11:0] r;
        if (!v[13] && (v[12:11] != 2'b00)) begin
            r = 12'h7FF;
        end else if (v[13] && (v[12:11] != 2'b11)) begin
            r = 12'h800;
        end else begin
            r = v[11:0];
        end
        return r;
    endfunction

endpackage

### rtl/dda_front.sv
// ----------------------------------------------------------------------------
// dda_front
// Accepts items, works out deltas, signs and major axis length of a load.
// ----------------------------------------------------------------------------
module dda_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  dda_pkg::t_dda_in      i_in_data,
    output logic                  o_in_stall,
    input  dda_pkg::t_dda_q_status i_q_st,
    output logic                  o_push,
    output dda_pkg::t_dda_cmd     o_cmd
);
    import dda_pkg::*;

    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic [16:0]        w_ndx;
    logic [16:0]        w_ndy;
    logic [15:0]        w_adx;
    logic [15:0]        w_ady;
    logic               r_seen_rst;

    // marks the first cycle out of reset, holds the queue back until then
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_rst <= 1'b0;
        end else begin
            r_seen_rst <= 1'b1;
        end
    end

    always_comb begin
        w_dx  = {i_in_data.end_x[15], i_in_data.end_x} -
                {i_in_data.start_x[15], i_in_data.start_x};
        w_dy  = {i_in_data.end_y[15], i_in_data.end_y} -
                {i_in_data.start_y[15], i_in_data.start_y};
        w_ndx = ~w_dx + 17'd1;
        w_ndy = ~w_dy + 17'd1;
        w_adx = w_dx[16] ? w_ndx[15:0] : w_dx[15:0];
        w_ady = w_dy[16] ? w_ndy[15:0] : w_dy[15:0];

        o_cmd.op      = i_in_data.op;
        o_cmd.start_x = i_in_data.start_x;
        o_cmd.start_y = i_in_data.start_y;
        o_cmd.mag_x   = w_adx;
        o_cmd.mag_y   = w_ady;
        o_cmd.neg_x   = w_dx[16];
        o_cmd.neg_y   = w_dy[16];
        o_cmd.up_x    = !w_dx[16] && (w_dx != 17'sd0);
        o_cmd.up_y    = !w_dy[16] && (w_dy != 17'sd0);
        o_cmd.len     = (w_adx > w_ady) ? w_adx : w_ady;
    end

    assign o_in_stall = i_q_st.full || !r_seen_rst;
    assign o_push     = i_in_valid && !o_in_stall;

endmodule

### rtl/dda_fifo.sv
// ----------------------------------------------------------------------------
// dda_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module dda_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  dda_pkg::t_dda_cmd      i_cmd,
    input  logic                   i_pop,
    output dda_pkg::t_dda_cmd      o_head,
    output dda_pkg::t_dda_q_status o_st
);
    import dda_pkg::*;

    t_dda_cmd           r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        logic [Q_PTR_W-1:0] r;
        if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + Q_PTR_W'(1);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    assign o_head   = r_mem[r_rd];
    assign o_st.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_st.empty = (r_cnt == '0);

endmodule

### rtl/dda_back.sv
// ----------------------------------------------------------------------------
// dda_back
// Runs queued commands: increment divide on load, at most one pixel per step.
// ----------------------------------------------------------------------------
module dda_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dda_pkg::t_dda_cmd      i_head,
    input  dda_pkg::t_dda_q_status i_q_st,
    output logic                   o_pop,
    output logic                   o_busy,
    input  logic [12:0]            i_img_w,
    input  logic [12:0]            i_img_h,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output dda_pkg::t_dda_out      o_out_data
);
    import dda_pkg::*;

    localparam int PW = FRAC_BITS + 14;
    localparam int SW = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam logic [PW-1:0] HALF = {{(PW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    t_back_state        r_state, n_state;
    logic [PW-1:0]      r_pos_x, n_pos_x;
    logic [PW-1:0]      r_pos_y, n_pos_y;
    logic [SW-1:0]      r_step_x, n_step_x;
    logic [SW-1:0]      r_step_y, n_step_y;
    logic [11:0]        r_left, n_left;
    logic [16:0]        r_rem_x, n_rem_x;
    logic [16:0]        r_rem_y, n_rem_y;
    logic [QW-1:0]      r_quo_x, n_quo_x;
    logic [QW-1:0]      r_quo_y, n_quo_y;
    logic [15:0]        r_len, n_len;
    logic               r_neg_x, n_neg_x;
    logic               r_neg_y, n_neg_y;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    t_dda_out           r_out, n_out;

    logic [PW-1:0]      w_sum_x;
    logic [PW-1:0]      w_sum_y;
    logic [13:0]        w_px;
    logic [13:0]        w_py;
    logic [QW-1:0]      w_qx;
    logic [QW-1:0]      w_qy;
    logic               w_can_out;

    function automatic logic [PW-1:0] start_pos(input logic [15:0] s, input logic up);
        logic [PW-1:0] base;
        base = {{(PW - 16){s[15]}}, s} << (FRAC_BITS - 4);
        return up ? (base + HALF) : (base - HALF);
    endfunction

    // integer part, rounded toward zero
    function automatic logic [13:0] trunc_int(input logic [PW-1:0] p);
        logic [PW-1:0] m;
        logic [13:0]   ip;
        m  = p[PW-1] ? (~p + PW'(1)) : p;
        ip = {1'b0, m[PW-2:FRAC_BITS]};
        return p[PW-1] ? (~ip + 14'd1) : ip;
    endfunction

    // one restoring divide step per lane: next remainder and quotient bit
    function automatic logic [17:0] div_step(input logic [16:0] rem, input logic [15:0] len);
        logic [16:0] diff;
        logic        ge;
        logic [16:0] kept;
        ge   = (rem >= {1'b0, len});
        diff = rem - {1'b0, len};
        kept = ge ? diff : rem;
        return {kept[15:0], 1'b0, ge};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_step_x    <= '0;
            r_step_y    <= '0;
            r_left      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_step_x    <= n_step_x;
            r_step_y    <= n_step_y;
            r_left      <= n_left;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem_x <= n_rem_x;
        r_rem_y <= n_rem_y;
        r_quo_x <= n_quo_x;
        r_quo_y <= n_quo_y;
        r_len   <= n_len;
        r_neg_x <= n_neg_x;
        r_neg_y <= n_neg_y;
        r_out   <= n_out;
    end

    always_comb begin
        logic [17:0] dx_st;
        logic [17:0] dy_st;

        n_state     = r_state;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_step_x    = r_step_x;
        n_step_y    = r_step_y;
        n_left      = r_left;
        n_rem_x     = r_rem_x;
        n_rem_y     = r_rem_y;
        n_quo_x     = r_quo_x;
        n_quo_y     = r_quo_y;
        n_len       = r_len;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;

        w_can_out = !r_out_valid || !i_out_stall;
        w_sum_x   = r_pos_x + {{(PW - SW){r_step_x[SW-1]}}, r_step_x};
        w_sum_y   = r_pos_y + {{(PW - SW){r_step_y[SW-1]}}, r_step_y};
        w_px      = trunc_int(w_sum_x);
        w_py      = trunc_int(w_sum_y);

        dx_st = div_step(r_rem_x, r_len);
        dy_st = div_step(r_rem_y, r_len);
        w_qx  = {r_quo_x[QW-2:0], dx_st[0]};
        w_qy  = {r_quo_y[QW-2:0], dy_st[0]};

        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_st.empty) begin
                    if (i_head.op == OP_LOAD) begin
                        o_pop   = 1'b1;
                        n_pos_x = start_pos(i_head.start_x, i_head.up_x);
                        n_pos_y = start_pos(i_head.start_y, i_head.up_y);
                        n_left  = i_head.len[15:4];
                        n_rem_x = {1'b0, i_head.mag_x};
                        n_rem_y = {1'b0, i_head.mag_y};
                        n_quo_x = '0;
                        n_quo_y = '0;
                        n_len   = i_head.len;
                        n_neg_x = i_head.neg_x;
                        n_neg_y = i_head.neg_y;
                        n_cnt   = CW'(FRAC_BITS);
                        if (i_head.len == 16'd0) begin
                            n_step_x = '0;
                            n_step_y = '0;
                        end else begin
                            n_state = BK_DIV;
                        end
                    end else if (r_left == 12'd0) begin
                        // nothing left on this line, drop the step
                        o_pop = 1'b1;
                    end else if (w_can_out) begin
                        o_pop            = 1'b1;
                        n_pos_x          = w_sum_x;
                        n_pos_y          = w_sum_y;
                        n_left           = r_left - 12'd1;
                        n_out_valid      = 1'b1;
                        n_out.pixel_x    = sat12(w_px);
                        n_out.pixel_y    = sat12(w_py);
                        n_out.inside_res = !w_px[13] && !w_py[13] &&
                                           (w_px[12:0] < i_img_w) &&
                                           (w_py[12:0] < i_img_h);
                        n_out.last       = (r_left == 12'd1);
                    end
                end
            end
            BK_DIV: begin
                n_rem_x = dx_st[17:1];
                n_rem_y = dy_st[17:1];
                n_quo_x = w_qx;
                n_quo_y = w_qy;
                if (r_cnt == '0) begin
                    n_step_x = r_neg_x ? (~{1'b0, w_qx} + SW'(1)) : {1'b0, w_qx};
                    n_step_y = r_neg_y ? (~{1'b0, w_qy} + SW'(1)) : {1'b0, w_qy};
                    n_state  = BK_IDLE;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state == BK_DIV);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/dda_line_rasterizer.sv
// Step items pass the queue write, then the result register; steady rate one step item per
// cycle while the back end is not dividing and the output is not stalled. A step on a
// finished line gives no result. A nonzero-length load is popped, then holds the back end for
// a restoring divide, x and y in parallel; the 2-entry queue keeps taking items meanwhile until full.
// Synchronous active-low reset: queue empty, line state zero, image size 400 x 400.
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line generator: load endpoints, then at most one pixel per step item.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  dda_pkg::t_dda_in                   i_in_data,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output dda_pkg::t_dda_out                  o_out_data,
    input  logic                               i_out_stall,
    input  logic                               i_cfg_we,
    input  logic [dda_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dda_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dda_pkg::*;

    logic [CFG_DATA_W-1:0] r_img_w;
    logic [CFG_DATA_W-1:0] r_img_h;
    t_dda_q_status         w_q_st;
    t_dda_cmd              w_cmd;
    t_dda_cmd              w_head;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_bk_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMG_SIZE_RESET;
            r_img_h <= IMG_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dda_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_st     (w_q_st),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    dda_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_st    (w_q_st)
    );

    dda_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_st      (w_q_st),
        .o_pop       (w_pop),
        .o_busy      (w_bk_busy),
        .i_img_w     (r_img_w),
        .i_img_h     (r_img_h),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // the back end takes nothing from the queue while dividing
    a_no_pop_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bk_busy |-> !w_pop)
        else $error("queue popped during increment divide");

    // a fresh result only follows a command taken from the queue
    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_pop))
        else $error("result raised without a queue pop");

    // never pop an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_st.empty)
        else $error("pop from empty queue");

endmodule
